// ----- rtl/core/tnc_pkg.sv -----
`default_nettype none

package tnc_pkg;

   // result field widths
   localparam int PIXEL_X_BITS = 12;
   localparam int PIXEL_Y_BITS = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;
   localparam int FRAME_WIDTH_BITS  = 13;
   localparam int FRAME_HEIGHT_BITS = 16;
   localparam int GRAD_THR_BITS     = 18;
   localparam int VERT_THR_BITS     = 17;

   // frame height reset is 4096 rows, held as the last row index
   localparam logic [FRAME_HEIGHT_BITS-1:0] RESET_LAST_ROW = 16'd4095;

   // queue between classifier and result side
   localparam int QDEPTH      = 8;
   localparam int QPTR_BITS   = 3;
   localparam int QLEVEL_BITS = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH        = 3'd0,
      CSR_FRAME_HEIGHT       = 3'd1,
      CSR_SLOPE_THRESHOLD    = 3'd2,
      CSR_FLAT_THRESHOLD     = 3'd3,
      CSR_VERTICAL_THRESHOLD = 3'd4,
      CSR_TERRACE_LOW        = 3'd5,
      CSR_TERRACE_HIGH       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_PLAIN    = 2'd0,
      CLASS_TERRACE  = 2'd1,
      CLASS_MOUNTAIN = 2'd2,
      CLASS_SLOPE    = 2'd3
   } class_type;

   // one classified sample: pixel above it and, in the last row, its own pixel
   typedef struct packed {
      logic [PIXEL_X_BITS-1:0] pixel_x;
      logic [PIXEL_Y_BITS-1:0] pixel_y;
      class_type               class_code;
      logic                    emit_above;
      logic                    emit_own;
   } rec_type;

endpackage

`default_nettype wire

// ----- rtl/core/terrace_neighbourhood_classifier.sv -----
// Terrace classifier for a raster heightmap. Samples enter one per clock in raster order
// through push/full; each sample (x,y) with y >= 1 classifies pixel (x,y-1) from its
// four-neighbour cross (left, right and centre from the row above, up from two rows above,
// down is the sample itself) as plain 0, terrace 1, mountain 2 or slope 3, precedence
// terrace, flat, mountain, slope, plain; frame border pixels are plain. A sample in the
// last row also yields its own pixel as a second, plain result, flagged last_of_run.
// Thresholds are unsigned integers in height units. The front takes one sample every
// clock: each line store is written once and read at no more than two addresses per
// sample, so the store ports set the rate at one sample per cycle; results leave at one
// per cycle while pop is high, so last-row samples (two results) drain slower. A result
// is visible after stages 1 to 3 and the 8-entry queue between front and result side;
// output stalls stop input once queued and in-flight samples fill the queue. After reset
// a clearing pass zeroes both line stores at all MAX_WIDTH addresses with full high;
// csr_ready is always high and registers may be written at any time the block is idle,
// including during the clearing pass.
`default_nettype none

module terrace_neighbourhood_classifier #(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // sample channel
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [SAMPLE_BITS-1:0]              req_height_sample,
   // result channel
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [tnc_pkg::PIXEL_X_BITS-1:0]         rsp_pixel_x,
   output logic [tnc_pkg::PIXEL_Y_BITS-1:0]         rsp_pixel_y,
   output logic [1:0]                               rsp_class_code,
   output logic                                     rsp_last_of_run,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tnc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tnc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // classified beats from the front into the queue
   logic                                q_push;
   tnc_pkg::rec_type                    q_rec;
   logic [tnc_pkg::QLEVEL_BITS-1:0]     q_level;
   // queue head toward the result side
   logic                                head_valid;
   tnc_pkg::rec_type                    head_rec;
   logic                                deq;

   // counters, line stores and the three-stage classifier
   tnc_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_height_sample (req_height_sample),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .q_level           (q_level),
      .q_push            (q_push),
      .q_rec             (q_rec)
   );

   // one entry per sample that has results; space is reserved before accept
   tnc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (q_push),
      .wr_rec     (q_rec),
      .rd_en      (deq),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .level      (q_level)
   );

   // splits an entry into one or two result beats
   tnc_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_rec        (head_rec),
      .deq             (deq),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_class_code  (rsp_class_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ----- rtl/core/tnc_front.sv -----
`default_nettype none

module tnc_front #(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic [SAMPLE_BITS-1:0]              req_height_sample,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tnc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [tnc_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic [tnc_pkg::QLEVEL_BITS-1:0]     q_level,
   output logic                                     q_push,
   output tnc_pkg::rec_type                         q_rec
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int GW = (SAMPLE_BITS + 2 > tnc_pkg::GRAD_THR_BITS) ?
                       SAMPLE_BITS + 2 : tnc_pkg::GRAD_THR_BITS;
   localparam int RESET_WIDTH = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
   localparam int LW = tnc_pkg::QLEVEL_BITS + 1;

   function automatic logic [SAMPLE_BITS-1:0] abs_diff(
      input logic [SAMPLE_BITS-1:0] a,
      input logic [SAMPLE_BITS-1:0] b
   );
      return (a >= b) ? a - b : b - a;
   endfunction

   // configuration
   logic [AW-1:0]                              last_col_ff, last_col_in;
   logic [tnc_pkg::FRAME_HEIGHT_BITS-1:0]      last_row_ff, last_row_in;
   logic [tnc_pkg::GRAD_THR_BITS-1:0]          slope_thr_ff, flat_thr_ff;
   logic [tnc_pkg::VERT_THR_BITS-1:0]          vert_thr_ff, terr_lo_ff, terr_hi_ff;
   logic [tnc_pkg::FRAME_WIDTH_BITS-1:0]       fw_wr;
   logic [tnc_pkg::FRAME_HEIGHT_BITS-1:0]      fh_wr;

   // clearing pass
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // raster position
   logic [AW-1:0]                         col_ff, col_in, x0, xr0;
   logic [tnc_pkg::FRAME_HEIGHT_BITS-1:0] row_ff, row_in, y0;
   logic accept, has_right0, row_end0, frame_end0, interior0;

   // line stores
   logic [SAMPLE_BITS-1:0] prev_mem [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0] centre_rd_ff, right_rd_ff, up_rd_ff;
   logic                   prev_we;
   logic [AW-1:0]          prev_wa;
   logic [SAMPLE_BITS-1:0] prev_wd;

   // stage 1: store data back
   logic                   s1_valid_ff;
   logic [AW-1:0]          s1_x_ff;
   logic [SAMPLE_BITS-1:0] s1_down_ff;
   logic                   s1_has_right_ff, s1_interior_ff;
   tnc_pkg::rec_type       s1_rec_ff, s1_rec_in;
   logic                   byp_ff, byp_in;
   logic [SAMPLE_BITS-1:0] byp_data_ff, left_ff;
   logic [SAMPLE_BITS-1:0] right1, up1;

   // stage 2: differences
   logic                   s2_valid_ff, s2_interior_ff;
   tnc_pkg::rec_type       s2_rec_ff;
   logic [SAMPLE_BITS-1:0] dl_ff, dr_ff, du_ff, dd_ff, vert_ff;
   logic [SAMPLE_BITS-1:0] dl_in, dr_in, du_in, dd_in, vert_in;

   // stage 3: gradient and threshold flags
   logic                   s3_valid_ff, s3_interior_ff;
   tnc_pkg::rec_type       s3_rec_ff;
   logic [GW-1:0]          grad_ff, grad_in;
   logic                   each_ok_ff, each_ok_in, v_lt_ff, v_lt_in;
   logic                   v_gt_ff, v_gt_in, terr_ff, terr_in;
   tnc_pkg::class_type     class3;

   logic [1:0]    inflight;
   logic [LW-1:0] occupancy;

   assign csr_ready = 1'b1;

   // geometry held as last column / last row, clamped at write time
   always_comb begin
      fw_wr = csr_data[tnc_pkg::FRAME_WIDTH_BITS-1:0];
      fh_wr = csr_data[tnc_pkg::FRAME_HEIGHT_BITS-1:0];
      if (fw_wr == '0) begin
         last_col_in = '0;
      end else if (32'(fw_wr) > 32'(MAX_WIDTH)) begin
         last_col_in = AW'(MAX_WIDTH - 1);
      end else begin
         last_col_in = AW'(fw_wr - 13'd1);
      end
      last_row_in = (fh_wr == '0) ? '0 : fh_wr - 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff  <= AW'(RESET_WIDTH - 1);
         last_row_ff  <= tnc_pkg::RESET_LAST_ROW;
         slope_thr_ff <= '0;
         flat_thr_ff  <= '0;
         vert_thr_ff  <= '0;
         terr_lo_ff   <= '0;
         terr_hi_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            tnc_pkg::CSR_FRAME_WIDTH:        last_col_ff  <= last_col_in;
            tnc_pkg::CSR_FRAME_HEIGHT:       last_row_ff  <= last_row_in;
            tnc_pkg::CSR_SLOPE_THRESHOLD:    slope_thr_ff <= csr_data;
            tnc_pkg::CSR_FLAT_THRESHOLD:     flat_thr_ff  <= csr_data;
            tnc_pkg::CSR_VERTICAL_THRESHOLD:
               vert_thr_ff <= csr_data[tnc_pkg::VERT_THR_BITS-1:0];
            tnc_pkg::CSR_TERRACE_LOW:
               terr_lo_ff <= csr_data[tnc_pkg::VERT_THR_BITS-1:0];
            tnc_pkg::CSR_TERRACE_HIGH:
               terr_hi_ff <= csr_data[tnc_pkg::VERT_THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // admission: clearing pass, or queue space taken by queued and in-flight items
   always_comb begin
      inflight  = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};
      occupancy = {1'b0, q_level} + LW'(inflight);
      full      = clr_ff || (occupancy >= LW'(tnc_pkg::QDEPTH));
      accept    = push && !full;
   end

   // stage 0: position, store addresses, counters
   always_comb begin
      x0         = (col_ff > last_col_ff) ? last_col_ff : col_ff;
      y0         = (row_ff > last_row_ff) ? last_row_ff : row_ff;
      has_right0 = x0 < last_col_ff;
      row_end0   = !has_right0;
      frame_end0 = y0 == last_row_ff;
      interior0  = (y0 >= 16'd2) && (x0 != '0) && has_right0;
      xr0        = has_right0 ? x0 + AW'(1) : x0;
      if (row_end0) begin
         col_in = '0;
         row_in = frame_end0 ? '0 : y0 + 16'd1;
      end else begin
         col_in = x0 + AW'(1);
         row_in = y0;
      end
      clr_in      = clr_ff && (clr_addr_ff != AW'(MAX_WIDTH - 1));
      clr_addr_in = clr_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
      prev_we     = clr_ff || accept;
      prev_wa     = clr_ff ? clr_addr_ff : x0;
      prev_wd     = clr_ff ? '0 : req_height_sample;
      byp_in      = s1_valid_ff && (s1_x_ff == x0);
      s1_rec_in.pixel_x    = tnc_pkg::PIXEL_X_BITS'(x0);
      s1_rec_in.pixel_y    = y0;
      s1_rec_in.class_code = tnc_pkg::CLASS_PLAIN;
      s1_rec_in.emit_above = y0 != '0;
      s1_rec_in.emit_own   = frame_end0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         left_ff     <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) begin
            left_ff <= centre_rd_ff;
         end
      end
   end

   // row above: written with the new sample, read at centre and right
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      centre_rd_ff <= prev_mem[x0];
      right_rd_ff  <= prev_mem[xr0];
   end

   // row two above: takes the old centre from the registered row-above read
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         older_mem[clr_addr_ff] <= '0;
      end else if (s1_valid_ff) begin
         older_mem[s1_x_ff] <= centre_rd_ff;
      end
      up_rd_ff <= older_mem[x0];
   end

   // stage 1: neighbours and absolute differences
   always_comb begin
      right1  = s1_has_right_ff ? right_rd_ff : '0;
      up1     = byp_ff ? byp_data_ff : up_rd_ff;
      dl_in   = abs_diff(centre_rd_ff, left_ff);
      dr_in   = abs_diff(centre_rd_ff, right1);
      du_in   = abs_diff(centre_rd_ff, up1);
      dd_in   = abs_diff(centre_rd_ff, s1_down_ff);
      vert_in = abs_diff(up1, s1_down_ff);
   end

   // stage 2: gradient sum and per-term compares
   always_comb begin
      grad_in    = GW'(dl_ff) + GW'(dr_ff) + GW'(du_ff) + GW'(dd_ff);
      each_ok_in = (GW'(dl_ff) < GW'(slope_thr_ff)) && (GW'(dr_ff) < GW'(slope_thr_ff)) &&
                   (GW'(du_ff) < GW'(slope_thr_ff)) && (GW'(dd_ff) < GW'(slope_thr_ff));
      v_lt_in    = GW'(vert_ff) < GW'(vert_thr_ff);
      v_gt_in    = GW'(vert_ff) > GW'(vert_thr_ff);
      terr_in    = (GW'(vert_ff) >= GW'(terr_lo_ff)) && (GW'(vert_ff) <= GW'(terr_hi_ff));
   end

   // stage 3: class by precedence
   always_comb begin
      if (!s3_interior_ff) begin
         class3 = tnc_pkg::CLASS_PLAIN;
      end else if (terr_ff) begin
         class3 = tnc_pkg::CLASS_TERRACE;
      end else if (grad_ff < GW'(flat_thr_ff)) begin
         class3 = tnc_pkg::CLASS_PLAIN;
      end else if (v_gt_ff) begin
         class3 = tnc_pkg::CLASS_MOUNTAIN;
      end else if ((grad_ff < GW'(slope_thr_ff)) && v_lt_ff && each_ok_ff) begin
         class3 = tnc_pkg::CLASS_SLOPE;
      end else begin
         class3 = tnc_pkg::CLASS_PLAIN;
      end
      q_rec            = s3_rec_ff;
      q_rec.class_code = class3;
      q_push           = s3_valid_ff && (s3_rec_ff.emit_above || s3_rec_ff.emit_own);
   end

   always_ff @(posedge clock) begin
      s1_x_ff         <= x0;
      s1_down_ff      <= req_height_sample;
      s1_has_right_ff <= has_right0;
      s1_interior_ff  <= interior0;
      s1_rec_ff       <= s1_rec_in;
      byp_ff          <= byp_in;
      byp_data_ff     <= centre_rd_ff;
      s2_interior_ff  <= s1_interior_ff;
      s2_rec_ff       <= s1_rec_ff;
      dl_ff           <= dl_in;
      dr_ff           <= dr_in;
      du_ff           <= du_in;
      dd_ff           <= dd_in;
      vert_ff         <= vert_in;
      s3_interior_ff  <= s2_interior_ff;
      s3_rec_ff       <= s2_rec_ff;
      grad_ff         <= grad_in;
      each_ok_ff      <= each_ok_in;
      v_lt_ff         <= v_lt_in;
      v_gt_ff         <= v_gt_in;
      terr_ff         <= terr_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/tnc_fifo.sv -----
`default_nettype none

module tnc_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire tnc_pkg::rec_type                 wr_rec,
   input  wire logic                             rd_en,
   output logic                                  head_valid,
   output tnc_pkg::rec_type                      head_rec,
   output logic [tnc_pkg::QLEVEL_BITS-1:0]       level
);

   tnc_pkg::rec_type                     slot_ff [tnc_pkg::QDEPTH];
   logic [tnc_pkg::QPTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [tnc_pkg::QLEVEL_BITS-1:0]      level_ff, level_in;
   logic                                 do_rd;

   always_comb begin
      do_rd      = rd_en && (level_ff != '0);
      wr_ptr_in  = wr_en ? wr_ptr_ff + 3'd1 : wr_ptr_ff;
      rd_ptr_in  = do_rd ? rd_ptr_ff + 3'd1 : rd_ptr_ff;
      level_in   = level_ff + {3'd0, wr_en} - {3'd0, do_rd};
      head_valid = level_ff != '0;
      head_rec   = slot_ff[rd_ptr_ff];
      level      = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_rec;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/tnc_emit.sv -----
`default_nettype none

module tnc_emit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               head_valid,
   input  wire tnc_pkg::rec_type                   head_rec,
   output logic                                    deq,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic [tnc_pkg::PIXEL_X_BITS-1:0]        rsp_pixel_x,
   output logic [tnc_pkg::PIXEL_Y_BITS-1:0]        rsp_pixel_y,
   output logic [1:0]                              rsp_class_code,
   output logic                                    rsp_last_of_run
);

   logic phase_ff, phase_in;
   logic show_own, take;

   always_comb begin
      show_own = phase_ff || !head_rec.emit_above;
      take     = pop && head_valid;
      deq      = take && (show_own || !head_rec.emit_own);
      phase_in = take ? (!show_own && head_rec.emit_own) : phase_ff;
      empty    = !head_valid;
      rsp_pixel_x     = head_rec.pixel_x;
      rsp_pixel_y     = show_own ? head_rec.pixel_y : head_rec.pixel_y - 16'd1;
      rsp_class_code  = show_own ? tnc_pkg::CLASS_PLAIN : head_rec.class_code;
      rsp_last_of_run = show_own || !head_rec.emit_own;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/tnc_checker.sv -----
`default_nettype none

module tnc_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                full,
   input  wire logic                                empty,
   input  wire logic                                pop,
   input  wire logic [tnc_pkg::PIXEL_X_BITS-1:0]    rsp_pixel_x,
   input  wire logic [tnc_pkg::PIXEL_Y_BITS-1:0]    rsp_pixel_y,
   input  wire logic [1:0]                          rsp_class_code,
   input  wire logic                                rsp_last_of_run
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
                            $stable(rsp_class_code) && $stable(rsp_last_of_run)))
      else $error("stalled result beat changed");

   // a non-final beat is followed by the sample's own pixel one row lower, plain
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_of_run) |=>
         (!empty && rsp_last_of_run && rsp_pixel_x == $past(rsp_pixel_x) &&
          rsp_pixel_y == $past(rsp_pixel_y) + 16'd1 &&
          rsp_class_code == tnc_pkg::CLASS_PLAIN))
      else $error("second beat of a sample malformed");

   // top row is border
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_pixel_y == 16'd0) |-> (rsp_class_code == tnc_pkg::CLASS_PLAIN))
      else $error("top row pixel not plain");

   // store clearing holds off samples right after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (full && empty))
      else $error("samples admitted before line store clear");

endmodule

bind terrace_neighbourhood_classifier tnc_checker u_tnc_checker (.*);

`default_nettype wire
